// ===== hw/rtl/mqf_pkg.sv =====
// Shared constants and codes for the multi-queue FIFO.
package mqf_pkg;

	localparam int DATA_W  = 32;
	localparam int QNUM_W  = 3;
	localparam int CFG_W   = 4;
	localparam int STAT_W  = 2;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;
	localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd3;

	localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

endpackage

// ===== hw/rtl/mqf_if.sv =====
// Request and response channel interfaces of the multi-queue FIFO.
interface mqf_req_if import mqf_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [QNUM_W-1:0]        queue_number;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, command, queue_number, push_value, input ready);
	modport sink   (input valid, command, queue_number, push_value, output ready);
endinterface

interface mqf_rsp_if import mqf_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] pop_value;
	logic [STAT_W-1:0]        status;

	modport source (output valid, pop_value, status, input ready);
	modport sink   (input valid, pop_value, status, output ready);
endinterface

// ===== hw/rtl/mqf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mqf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/multi_queue_fifo.sv =====
// Bank of independent FIFO queues sharing one entry RAM and one pointer RAM.
//
// Usage: each beat on req carries a push (command 0) or a pop (command 1) to
// one queue; each request yields exactly one beat on rsp with pop_value and
// status (0 ok, 1 empty, 2 invalid queue, 3 full). A queue number at or above
// active_queues or NUM_QUEUES is invalid. An empty pop returns -1; a push to a
// full queue drops the value. active_queues resets to 8 and is written through
// cfg_we and cfg_wdata; the user must write it only while no request is in
// flight, as the block does not enforce this.
// Timing: a request is taken in ST_IDLE and its pointer record is read from the
// pointer RAM; in ST_UPD the record is updated together with the entry RAM
// access, and in ST_OUT the result enters the output register. req.ready is
// high only in ST_IDLE, so no request is taken until the last one is output.
// Reset clears the pointer records at once through per-queue valid bits, so
// every queue starts empty; the entry RAM is not cleared.
// A stalled response is held in the output register; one more request is
// taken and processed behind it, and then req.ready stays low until rsp drains.
module multi_queue_fifo import mqf_pkg::*; #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	mqf_req_if.sink          req,
	mqf_rsp_if.source        rsp
);

	localparam int QA_W    = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
	localparam int QX_W    = QA_W + QNUM_W;
	localparam int P_W     = $clog2(QUEUE_DEPTH);
	localparam int C_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int E_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int E_W     = $clog2(E_DEPTH);
	localparam int R_W     = 2 * P_W + C_W;

	typedef struct packed {
		logic [P_W-1:0] head;
		logic [P_W-1:0] tail;
		logic [C_W-1:0] cnt;
	} ptr_rec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_OUT
	} state_t;

	function automatic logic [P_W-1:0] next_slot(input logic [P_W-1:0] p);
		return (p == P_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t                   state_q;
	logic [CFG_W-1:0]         active_q_q;
	logic [NUM_QUEUES-1:0]    ptr_vld_q;

	logic                     cmd_s1;
	logic                     ok_s1;
	logic [QA_W-1:0]          q_s1;
	logic [E_W-1:0]           base_s1;
	logic [DATA_W-1:0]        val_s1;

	logic                     pop_s2;
	logic [STAT_W-1:0]        status_s2;

	logic                     rsp_valid_q;
	logic [DATA_W-1:0]        rsp_value_q;
	logic [STAT_W-1:0]        rsp_status_q;

	logic                     req_acc;
	logic [QX_W-1:0]          q_ext;
	logic [QA_W-1:0]          q_addr;
	logic                     q_ok;

	logic [R_W-1:0]           ptr_rdata;
	ptr_rec_t                 rec;
	ptr_rec_t                 rec_new;
	logic                     ptr_we;
	logic                     full;
	logic                     empty;
	logic                     push_ok;
	logic                     pop_ok;
	logic [STAT_W-1:0]        status_c;

	logic                     ent_we;
	logic                     ent_re;
	logic [E_W-1:0]           ent_waddr;
	logic [E_W-1:0]           ent_raddr;
	logic [DATA_W-1:0]        ent_rdata;
	logic                     out_free;

	// accept stage
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign q_ext     = QX_W'(req.queue_number);
	assign q_addr    = q_ext[QA_W-1:0];
	assign q_ok      = ({1'b0, req.queue_number} < active_q_q) &&
	                   (q_ext < QX_W'(NUM_QUEUES));

	// update stage
	always_comb begin
		rec      = ptr_vld_q[q_s1] ? ptr_rec_t'(ptr_rdata) : '0;
		full     = (rec.cnt == C_W'(QUEUE_DEPTH));
		empty    = (rec.cnt == '0);
		push_ok  = ok_s1 && (cmd_s1 == CMD_PUSH) && !full;
		pop_ok   = ok_s1 && (cmd_s1 == CMD_POP) && !empty;
		rec_new  = rec;
		if (push_ok) begin
			rec_new.tail = next_slot(rec.tail);
			rec_new.cnt  = rec.cnt + 1'b1;
		end
		if (pop_ok) begin
			rec_new.head = next_slot(rec.head);
			rec_new.cnt  = rec.cnt - 1'b1;
		end
		if (!ok_s1) begin
			status_c = STATUS_INVALID;
		end else if (cmd_s1 == CMD_PUSH) begin
			status_c = full ? STATUS_FULL : STATUS_OK;
		end else begin
			status_c = empty ? STATUS_EMPTY : STATUS_OK;
		end
	end

	assign ptr_we    = (state_q == ST_UPD) && (push_ok || pop_ok);
	assign ent_we    = (state_q == ST_UPD) && push_ok;
	assign ent_re    = (state_q == ST_UPD) && pop_ok;
	assign ent_waddr = base_s1 + E_W'(rec.tail);
	assign ent_raddr = base_s1 + E_W'(rec.head);
	assign out_free  = !rsp_valid_q || rsp.ready;

	mqf_ram #(
		.WIDTH (R_W),
		.DEPTH (NUM_QUEUES)
	) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (q_s1),
		.wdata (R_W'(rec_new)),
		.re    (req_acc),
		.raddr (q_addr),
		.rdata (ptr_rdata)
	);

	mqf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (E_DEPTH)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (val_s1),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_vld_q <= '0;
		end else if (ptr_we) begin
			ptr_vld_q[q_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_s1       <= CMD_PUSH;
			ok_s1        <= 1'b0;
			q_s1         <= '0;
			base_s1      <= '0;
			val_s1       <= '0;
			pop_s2       <= 1'b0;
			status_s2    <= STATUS_OK;
			rsp_valid_q  <= 1'b0;
			rsp_value_q  <= '0;
			rsp_status_q <= STATUS_OK;
		end else begin
			if (rsp.ready && !((state_q == ST_OUT) && out_free)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						cmd_s1  <= req.command;
						ok_s1   <= q_ok;
						q_s1    <= q_addr;
						base_s1 <= E_W'(q_addr) * E_W'(QUEUE_DEPTH);
						val_s1  <= req.push_value;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					pop_s2    <= pop_ok;
					status_s2 <= status_c;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_s2;
						if (pop_s2) begin
							rsp_value_q <= ent_rdata;
						end else if (status_s2 == STATUS_EMPTY) begin
							rsp_value_q <= EMPTY_VALUE;
						end else begin
							rsp_value_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pop_value = rsp_value_q;
	assign rsp.status    = rsp_status_q;

`ifndef NO_ASSERTIONS
	a_acc_upd: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == ST_UPD))
		else $error("accepted beat did not reach the update stage");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_we |-> (rec_new.cnt <= C_W'(QUEUE_DEPTH)))
		else $error("fill count exceeds queue depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ent_re |-> (rec.cnt != '0))
		else $error("entry read from an empty queue");

	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && out_free) |=> rsp_valid_q)
		else $error("finished result not presented on rsp");
`endif

endmodule

// ===== verif/tb.sv =====
// Testbench for multi_queue_fifo: push/pop traffic with random stalls, checked beat by beat.
`timescale 1ns / 100ps

module tb;
	import mqf_pkg::*;

	localparam int NUM_Q = 8;
	localparam int DEPTH = 16;

	typedef struct packed {
		logic                     command;
		logic [QNUM_W-1:0]        queue_number;
		logic signed [DATA_W-1:0] push_value;
	} fifo_request_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pop_value;
		logic [STAT_W-1:0]        status;
	} fifo_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	mqf_req_if req();
	mqf_rsp_if rsp();

	multi_queue_fifo #(
		.NUM_QUEUES(NUM_Q),
		.QUEUE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	logic signed [DATA_W-1:0] queue_slots [NUM_Q][DEPTH];
	int head_slot [NUM_Q];
	int tail_slot [NUM_Q];
	int fill_level [NUM_Q];
	int active_count = ACTIVE_RESET;

	fifo_request_t pending_requests [$];
	fifo_result_t  expected_results [$];
	fifo_request_t beat_req;
	fifo_request_t next_req;
	fifo_result_t  want;

	int idle_pct;
	int send_gap;
	int sink_gap;
	int long_hold;
	int result_beats;
	int failures;
	int settings_done;
	int status_seen [4];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic fifo_result_t queue_bank_apply(input fifo_request_t r);
		fifo_result_t res;
		int q;
		q = int'(r.queue_number);
		res.pop_value = '0;
		res.status = STATUS_OK;
		if (q >= NUM_Q || q >= active_count) begin
			res.status = STATUS_INVALID;
		end else if (r.command == CMD_PUSH) begin
			if (fill_level[q] >= DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				queue_slots[q][tail_slot[q]] = r.push_value;
				tail_slot[q] = (tail_slot[q] == DEPTH - 1) ? 0 : tail_slot[q] + 1;
				fill_level[q]++;
			end
		end else begin
			if (fill_level[q] == 0) begin
				res.status = STATUS_EMPTY;
				res.pop_value = EMPTY_VALUE;
			end else begin
				res.pop_value = queue_slots[q][head_slot[q]];
				head_slot[q] = (head_slot[q] == DEPTH - 1) ? 0 : head_slot[q] + 1;
				fill_level[q]--;
			end
		end
		return res;
	endfunction

	function automatic void log_mismatch(input string what, input logic [DATA_W-1:0] exp_val,
			input logic [DATA_W-1:0] got_val);
		if (failures < 40)
			$display("t=%0t %s mismatch: expected %h, actual %h", $time, what, exp_val, got_val);
		failures++;
	endfunction

	task automatic add_request(input logic cmd, input int q, input logic [DATA_W-1:0] value);
		fifo_request_t r;
		r.command = cmd;
		r.queue_number = q[QNUM_W-1:0];
		r.push_value = value;
		pending_requests.push_back(r);
	endtask

	task automatic queue_random_traffic(input int count);
		int push_pct;
		int focus;
		int pick;
		int live;
		logic [DATA_W-1:0] value;
		push_pct = 80;
		focus = 0;
		live = (active_count > NUM_Q) ? NUM_Q : active_count;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				push_pct = ((i / 40) % 2 == 0) ? 80 : 25;
				focus = (live > 0) ? $urandom_range(0, live - 1) : $urandom_range(0, NUM_Q - 1);
			end
			pick = $urandom_range(0, 15);
			value = (pick == 0) ? 32'h7fffffff : (pick == 1) ? 32'h80000000 : $urandom;
			pick = $urandom_range(0, 9);
			if (pick < 4)
				add_request(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP, focus, value);
			else if (pick < 8 && live > 0)
				add_request(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
					$urandom_range(0, live - 1), value);
			else
				add_request(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
					$urandom_range(0, NUM_Q - 1), value);
		end
	endtask

	task automatic wait_quiet();
		while (pending_requests.size() != 0 || expected_results.size() != 0 || req.valid)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_active_queues(input int count);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= count[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		active_count = count;
		settings_done++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.command <= CMD_PUSH;
			req.queue_number <= '0;
			req.push_value <= '0;
			send_gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				beat_req.command = req.command;
				beat_req.queue_number = req.queue_number;
				beat_req.push_value = req.push_value;
				expected_results.push_back(queue_bank_apply(beat_req));
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (pending_requests.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
					send_gap = $urandom_range(0, 7);
					req.valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_req = pending_requests.pop_front();
					req.valid <= 1'b1;
					req.command <= next_req.command;
					req.queue_number <= next_req.queue_number;
					req.push_value <= next_req.push_value;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			sink_gap = 0;
			long_hold = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				result_beats++;
				status_seen[rsp.status]++;
				if (expected_results.size() == 0) begin
					if (failures < 40)
						$display("t=%0t unexpected beat: expected none, actual %h / %0d",
							$time, rsp.pop_value, rsp.status);
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.pop_value !== want.pop_value)
						log_mismatch("pop_value", want.pop_value, rsp.pop_value);
					if (rsp.status !== want.status)
						log_mismatch("status", DATA_W'(want.status), DATA_W'(rsp.status));
				end
				if (result_beats == 400)
					long_hold = 150;
			end
			if (long_hold > 0) begin
				long_hold--;
				rsp.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				rsp.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				sink_gap = $urandom_range(0, 7);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 20;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_active_queues(ACTIVE_RESET);

		add_request(CMD_POP, 0, 32'h0);
		add_request(CMD_PUSH, 0, 32'h7fffffff);
		add_request(CMD_PUSH, 0, 32'h80000000);
		add_request(CMD_PUSH, 7, 32'hffffffff);
		add_request(CMD_POP, 0, 32'hffffffff);
		add_request(CMD_POP, 0, 32'h0);
		add_request(CMD_POP, 7, 32'h5a5a5a5a);
		for (int i = 0; i < DEPTH + 1; i++)
			add_request(CMD_PUSH, 5, 32'h1000 + i);
		add_request(CMD_POP, 5, 32'h0);
		wait_quiet();

		set_active_queues(1);
		idle_pct = 30;
		queue_random_traffic(300);
		wait_quiet();

		set_active_queues(3);
		idle_pct = 15;
		queue_random_traffic(300);
		wait_quiet();

		set_active_queues(0);
		idle_pct = 0;
		queue_random_traffic(100);
		wait_quiet();

		set_active_queues(15);
		idle_pct = 25;
		queue_random_traffic(300);
		wait_quiet();

		set_active_queues(5);
		idle_pct = 40;
		queue_random_traffic(300);
		wait_quiet();

		set_active_queues(2);
		idle_pct = 10;
		queue_random_traffic(300);
		wait_quiet();

		set_active_queues(8);
		idle_pct = 0;
		queue_random_traffic(375);
		wait_quiet();

		$display("Ran %0d push/pop beats across %0d queue-count settings.",
			result_beats, settings_done);
		$display("Results: %0d ok, %0d empty pops, %0d invalid queue, %0d full pushes.",
			status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
			status_seen[STATUS_INVALID], status_seen[STATUS_FULL]);
		if (failures == 0 && expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
